// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/zscr_pkg.sv =====
package zscr_pkg;

    localparam int DATA_W  = 32;
    localparam int TRIG_W  = 18;
    localparam int NUM_EL  = 6;
    localparam int VEC_W   = NUM_EL * DATA_W;
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;
    // wide enough for any sum that needs clamping in this block
    localparam int SUM_W   = 2 * DATA_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_SPATIAL_TO   = 2'd0,
        OP_SPATIAL_FROM = 2'd1,
        OP_ROTATE_TO    = 2'd2,
        OP_ROTATE_FROM  = 2'd3
    } t_op;

    localparam logic [1:0] REG_COS    = 2'd0;
    localparam logic [1:0] REG_SIN    = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    typedef struct packed {
        logic load;
        logic from_inboard;
    } t_stage_ctl;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh0000_0000_8000_0000);

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] res;
        if (x > SAT_HI) begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < SAT_LO) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/zscr_offset.sv =====
module zscr_offset #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  zscr_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_d,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_v0,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_v1,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_v3,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_v4,
    output logic signed [zscr_pkg::DATA_W-1:0]   o_ta,
    output logic signed [zscr_pkg::DATA_W-1:0]   o_tb
);
    import zscr_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic signed [PROD_W-1:0] r_prod_m, r_prod_p;
    logic signed [DATA_W-1:0] r_base_m, r_base_p;
    logic signed [DATA_W-1:0] n_base_m, n_base_p, w_mul_m, w_mul_p;
    logic signed [PROD_W-1:0] w_sh_m, w_sh_p;

    // moment shift: to inboard uses (v0,v4)/(v1,v3), from inboard (v4,v0)/(v3,v1)
    always_comb begin
        if (i_ctl.from_inboard) begin
            n_base_m = i_v4;
            w_mul_m  = i_v0;
            n_base_p = i_v3;
            w_mul_p  = i_v1;
        end else begin
            n_base_m = i_v0;
            w_mul_m  = i_v4;
            n_base_p = i_v1;
            w_mul_p  = i_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod_m <= i_d * w_mul_m;
            r_prod_p <= i_d * w_mul_p;
            r_base_m <= n_base_m;
            r_base_p <= n_base_p;
        end
    end

    assign w_sh_m = r_prod_m >>> FRAC_BITS;
    assign w_sh_p = r_prod_p >>> FRAC_BITS;
    assign o_ta = sat_word(SUM_W'(r_base_m) - SUM_W'(w_sh_m));
    assign o_tb = sat_word(SUM_W'(r_base_p) + SUM_W'(w_sh_p));

endmodule

// ===== rtl/zscr_lane.sv =====
module zscr_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  zscr_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [zscr_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [zscr_pkg::TRIG_W-1:0]   i_sin,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_a,
    input  logic signed [zscr_pkg::DATA_W-1:0]   i_b,
    output logic signed [zscr_pkg::DATA_W-1:0]   o_r0,
    output logic signed [zscr_pkg::DATA_W-1:0]   o_r1
);
    import zscr_pkg::*;

    localparam int PROD_W = DATA_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] r_ac, r_bs, r_bc, r_as;
    logic                     r_from;
    logic signed [PROD_W-1:0] w_ac, w_bs, w_bc, w_as;
    logic signed [ACC_W-1:0]  w_sum0, w_sum1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ac   <= i_a * i_cos;
            r_bs   <= i_b * i_sin;
            r_bc   <= i_b * i_cos;
            r_as   <= i_a * i_sin;
            r_from <= i_ctl.from_inboard;
        end
    end

    assign w_ac = r_ac >>> FRAC_BITS;
    assign w_bs = r_bs >>> FRAC_BITS;
    assign w_bc = r_bc >>> FRAC_BITS;
    assign w_as = r_as >>> FRAC_BITS;

    // R transposed applied going out of the inboard frame, R applied going in
    always_comb begin
        if (r_from) begin
            w_sum0 = ACC_W'(w_ac) + ACC_W'(w_bs);
            w_sum1 = ACC_W'(w_bc) - ACC_W'(w_as);
        end else begin
            w_sum0 = ACC_W'(w_ac) - ACC_W'(w_bs);
            w_sum1 = ACC_W'(w_bc) + ACC_W'(w_as);
        end
    end

    assign o_r0 = sat_word(SUM_W'(w_sum0));
    assign o_r1 = sat_word(SUM_W'(w_sum1));

endmodule

// ===== rtl/z_screw_spatial_transform.sv =====
// Screw transform about z of a 6-element Q16.16 vector (or a rotation of its
// first three elements), one beat in and one beat out per item. The pipeline
// has four register stages: offset multiply, offset add/clamp, rotation
// multiply in two lanes, and the merge into the output register. Throughput
// is one item per clock while m_tready is high; an accepted s_tdata beat passes
// through each stage register in order into the output register. Each stage
// advances when it is empty or the stage after it advances, so free stages keep taking beats while m_tready is low.
// Configuration registers (APB, byte addresses): 0x0 cos_theta, 0x4 sin_theta,
// 0x8 offset_d; write them only while no item is in flight.
module z_screw_spatial_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [zscr_pkg::VEC_W-1:0]      s_tdata,   // in_0 .. in_5, 32 bits each
    input  logic [zscr_pkg::OP_W-1:0]       s_tuser,   // op
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [zscr_pkg::VEC_W-1:0]      m_tdata,   // out_0 .. out_5, 32 bits each
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zscr_pkg::ADDR_W-1:0]     paddr,
    input  logic [zscr_pkg::APB_W-1:0]      pwdata,
    output logic [zscr_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);
    import zscr_pkg::*;

    localparam logic signed [TRIG_W-1:0] COS_ONE = TRIG_W'(64'sd1 <<< FRAC_BITS);

    // config registers
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic signed [DATA_W-1:0] r_offset;
    logic                     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= COS_ONE;
            r_sin    <= '0;
            r_offset <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_COS:    r_cos    <= pwdata[TRIG_W-1:0];
                REG_SIN:    r_sin    <= pwdata[TRIG_W-1:0];
                REG_OFFSET: r_offset <= pwdata[DATA_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COS:    prdata = APB_W'(r_cos);
            REG_SIN:    prdata = APB_W'(r_sin);
            REG_OFFSET: prdata = APB_W'(r_offset);
            default:    prdata = '0;
        endcase
    end

    // pipeline flow control
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4    = !r_v4 || m_tready;
    assign w_en3    = !r_v3 || w_en4;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign s_tready = w_en1;
    assign m_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: unpack, offset products
    logic signed [DATA_W-1:0] w_in [NUM_EL];
    logic signed [DATA_W-1:0] r_s1_in [NUM_EL];
    t_op                      w_op, r_s1_op;
    t_stage_ctl               w_ofs_ctl;
    logic signed [DATA_W-1:0] w_ta, w_tb;

    for (genvar g = 0; g < NUM_EL; g++) begin : g_unpack
        assign w_in[g] = s_tdata[g*DATA_W +: DATA_W];
    end

    assign w_op = t_op'(s_tuser);
    assign w_ofs_ctl.load         = w_en1;
    assign w_ofs_ctl.from_inboard = (w_op == OP_SPATIAL_FROM) || (w_op == OP_ROTATE_FROM);

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_in <= w_in;
            r_s1_op <= w_op;
        end
    end

    zscr_offset #(
        .FRAC_BITS (FRAC_BITS)
    ) u_offset (
        .i_clk (i_clk),
        .i_ctl (w_ofs_ctl),
        .i_d   (r_offset),
        .i_v0  (w_in[0]),
        .i_v1  (w_in[1]),
        .i_v3  (w_in[3]),
        .i_v4  (w_in[4]),
        .o_ta  (w_ta),
        .o_tb  (w_tb)
    );

    // stage 2: lane operands
    logic signed [DATA_W-1:0] r_s2_ua, r_s2_ub, r_s2_la, r_s2_lb, r_s2_in2, r_s2_in5;
    logic signed [DATA_W-1:0] n_s2_ua, n_s2_ub, n_s2_la, n_s2_lb;
    t_op                      r_s2_op;

    always_comb begin
        unique case (r_s1_op) inside
            OP_SPATIAL_TO: begin
                n_s2_ua = w_ta;
                n_s2_ub = w_tb;
                n_s2_la = r_s1_in[3];
                n_s2_lb = r_s1_in[4];
            end
            OP_SPATIAL_FROM: begin
                n_s2_ua = r_s1_in[0];
                n_s2_ub = r_s1_in[1];
                n_s2_la = w_tb;
                n_s2_lb = w_ta;
            end
            OP_ROTATE_TO, OP_ROTATE_FROM: begin
                n_s2_ua = r_s1_in[0];
                n_s2_ub = r_s1_in[1];
                n_s2_la = r_s1_in[3];
                n_s2_lb = r_s1_in[4];
            end
            default: begin
                n_s2_ua = r_s1_in[0];
                n_s2_ub = r_s1_in[1];
                n_s2_la = r_s1_in[3];
                n_s2_lb = r_s1_in[4];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_ua  <= n_s2_ua;
            r_s2_ub  <= n_s2_ub;
            r_s2_la  <= n_s2_la;
            r_s2_lb  <= n_s2_lb;
            r_s2_in2 <= r_s1_in[2];
            r_s2_in5 <= r_s1_in[5];
            r_s2_op  <= r_s1_op;
        end
    end

    // stage 3: rotation lanes
    t_stage_ctl               w_lane_ctl;
    logic signed [DATA_W-1:0] w_u0, w_u1, w_l0, w_l1;
    logic signed [DATA_W-1:0] r_s3_in2, r_s3_in5;
    t_op                      r_s3_op;

    assign w_lane_ctl.load         = w_en3;
    assign w_lane_ctl.from_inboard = (r_s2_op == OP_SPATIAL_FROM) ||
                                     (r_s2_op == OP_ROTATE_FROM);

    zscr_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_upper (
        .i_clk (i_clk),
        .i_ctl (w_lane_ctl),
        .i_cos (r_cos),
        .i_sin (r_sin),
        .i_a   (r_s2_ua),
        .i_b   (r_s2_ub),
        .o_r0  (w_u0),
        .o_r1  (w_u1)
    );

    zscr_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_lower (
        .i_clk (i_clk),
        .i_ctl (w_lane_ctl),
        .i_cos (r_cos),
        .i_sin (r_sin),
        .i_a   (r_s2_la),
        .i_b   (r_s2_lb),
        .o_r0  (w_l0),
        .o_r1  (w_l1)
    );

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_in2 <= r_s2_in2;
            r_s3_in5 <= r_s2_in5;
            r_s3_op  <= r_s2_op;
        end
    end

    // stage 4: merge lanes into the output beat
    logic signed [DATA_W-1:0] r_out [NUM_EL];
    logic signed [DATA_W-1:0] n_out [NUM_EL];
    logic                     w_rot_only;

    assign w_rot_only = (r_s3_op == OP_ROTATE_TO) || (r_s3_op == OP_ROTATE_FROM);

    always_comb begin
        n_out[0] = w_u0;
        n_out[1] = w_u1;
        n_out[2] = r_s3_in2;
        if (w_rot_only) begin
            n_out[3] = '0;
            n_out[4] = '0;
            n_out[5] = '0;
        end else begin
            n_out[3] = w_l0;
            n_out[4] = w_l1;
            n_out[5] = r_s3_in5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out <= n_out;
        end
    end

    for (genvar g = 0; g < NUM_EL; g++) begin : g_pack
        assign m_tdata[g*DATA_W +: DATA_W] = r_out[g];
    end

endmodule

// ===== rtl/zscr_checker.sv =====
`include "assert_macros.svh"

module zscr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [zscr_pkg::OP_W-1:0]    s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [zscr_pkg::VEC_W-1:0]   m_tdata,
    input logic                         pready
);
    import zscr_pkg::*;

    localparam int HALF_W = VEC_W / 2;

    // a stalled output beat stays valid
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid, "output beat dropped while stalled")

    // with the output register empty the whole pipeline can move
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !m_tvalid |-> s_tready, "input blocked with empty output")

    // a rotate beat with no stall reaches the output register with its upper half zero
    `ASSERT_CLK(a_rotate_zero, i_clk, i_rst_n, (s_tvalid && s_tready && s_tuser[1]) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid && (m_tdata[VEC_W-1:HALF_W] == '0), "rotate beat late or upper elements nonzero")

    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_tvalid && pready, "output valid after reset")

endmodule

bind z_screw_spatial_transform zscr_checker u_zscr_checker (.*);
